// ===== hdl/i2da_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants, types and state codes for the binary to decimal ASCII
// converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int VALUE_WIDTH = 64;
    // Decimal digits needed for 2**VALUE_WIDTH - 1 (log10(2) ~ 0.30103).
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_WIDTH   = $clog2(NUM_DIGITS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_WIDTH  = 6;
    localparam int WORD_WIDTH  = 64;
    localparam int OUT_TDATA_WIDTH = 8;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 6'd57;

    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } i2da_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_COUNT,
        ST_SIGN,
        ST_DIGITS
    } i2da_state_t;

endpackage

// ===== hdl/i2da_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_front
// Input side: accepts a word, decides its sign and forms the magnitude that
// the conversion unit works on.
// ----------------------------------------------------------------------------
module i2da_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic                          s_axis_tuser,   // func
    input  logic [i2da_pkg::WORD_WIDTH-1:0] s_axis_tdata, // word
    output logic                          push_valid,
    input  logic                          push_ready,
    output i2da_pkg::i2da_item_t          push_item
);
    import i2da_pkg::*;

    logic [VALUE_WIDTH-1:0] value;
    logic                   neg;

    assign value = s_axis_tdata[VALUE_WIDTH-1:0];
    assign neg   = s_axis_tuser & value[VALUE_WIDTH-1];

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;

    // Two's complement negation; the most negative value maps onto itself,
    // which read as unsigned is exactly its magnitude.
    assign push_item.neg = neg;
    assign push_item.mag = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;

endmodule

// ===== hdl/i2da_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_queue
// Short FIFO between the input side and the conversion unit.
// ----------------------------------------------------------------------------
module i2da_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  i2da_pkg::i2da_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output i2da_pkg::i2da_item_t pop_item
);
    import i2da_pkg::*;

    i2da_item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0]  count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/i2da_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_back
// Conversion unit: shift-and-add-3 binary to BCD, one bit per cycle, then
// emits the sign and the significant digits through an output register.
// ----------------------------------------------------------------------------
module i2da_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  i2da_pkg::i2da_item_t q_item,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [i2da_pkg::CHAR_WIDTH-1:0] m_char,
    output logic                 m_axis_tlast
);
    import i2da_pkg::*;

    i2da_state_t            state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]   bcd_reg, bcd_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [IDX_WIDTH-1:0]   idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_WIDTH-1:0]  m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic [IDX_WIDTH-1:0]   top_idx;
    logic [3:0]             cur_digit;
    logic                   out_free;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // Every BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                             : bcd_reg[i*4 +: 4];
        end
    end

    // Highest nonzero digit; zero leaves index 0 so that a single '0' goes out.
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] != 4'd0) begin
                top_idx = IDX_WIDTH'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    neg_next   = q_item.neg;
                    bin_next   = q_item.mag;
                    bcd_next   = '0;
                    cnt_next   = CNT_WIDTH'(VALUE_WIDTH);
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                bcd_next = {bcd_adj[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                idx_next   = top_idx;
                state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_ZERO + {2'b00, cur_digit};
                    m_last_next  = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_char        = m_char_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== hdl/int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a 64-bit integer, signed or unsigned, into its decimal ASCII text,
// one character per output word, most significant digit first.
//
//   Channel   Direction  tdata               tuser   tlast
//   s_axis    in         [63:0] word         func    -
//   m_axis    out        [5:0] char_code     -       last character
//
// A number passes through the queue, the bit-serial BCD converter (one input
// bit per cycle) and a step that finds its top digit, and then goes out
// character by character; a number has at most 20 characters. The next
// number waits in a two-entry queue meanwhile.
// Reset is synchronous and clears the queue, the sequencer and the output
// valid. A stall on m_axis holds the current character; s_axis stalls only
// when the queue is full.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [i2da_pkg::WORD_WIDTH-1:0]      s_axis_tdata,  // [63:0] word
    input  logic                                 s_axis_tuser,  // [0] func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [i2da_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,  // [5:0] char_code
    output logic                                 m_axis_tlast
);
    import i2da_pkg::*;

    logic                  push_valid;
    logic                  push_ready;
    i2da_item_t            push_item;
    logic                  q_valid;
    logic                  q_pop;
    i2da_item_t            q_item;
    logic [CHAR_WIDTH-1:0] m_char;

    i2da_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    i2da_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    i2da_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_char        (m_char),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_WIDTH-CHAR_WIDTH){1'b0}}, m_char};

    // Every character is a minus sign or a decimal digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_char == CH_MINUS) || ((m_char >= CH_ZERO) && (m_char <= CH_NINE)))
    else $error("character code out of range");

    // The minus sign always has a digit after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_char == CH_MINUS)) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

    // The digit that follows an accepted minus sign on the output is never a leading zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && (m_char == CH_MINUS)) ##1 m_axis_tvalid
        |-> (m_char != CH_ZERO))
    else $error("leading zero after minus sign");

    // Nothing leaves the block in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
